>>> sv/tpa_pkg.sv
// Trim pause advisor: shared types, widths and constants.
// Used by every module of the block; depends on nothing else.

package tpa_pkg;

  // History ring depth (oldest to youngest cells)
  localparam int HISTORY_DEPTH = 4;

  // Field widths
  localparam int STAMP_W = 48;
  localparam int DUR_W   = 32;
  localparam int SIZE_W  = 48;
  localparam int IVL_W   = 32;

  // Wide product widths of the pair judgment
  localparam int DUR100_W = 39;
  localparam int LHS_W    = 80;
  localparam int RHS_W    = 96;

  // Cost test: trim counts as costly when duration * 100 >= gap
  localparam logic [DUR100_W-1:0] COST_FACTOR = DUR100_W'(100);

  // Internal counter width: holds the depth and the 3-bit field
  localparam int CNT_W = ($clog2(HISTORY_DEPTH + 1) > 3) ? $clog2(HISTORY_DEPTH + 1) : 3;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_INTERVAL = CFG_IDX_W'(1);

  // One trim record
  typedef struct packed {
    logic [STAMP_W-1:0] trim_stamp_ms;
    logic [DUR_W-1:0]   trim_duration_ms;
    logic [SIZE_W-1:0]  size_before;
    logic [SIZE_W-1:0]  size_after;
    logic               measured;
  } tpa_in_t;

  // One advice result
  typedef struct packed {
    logic             advise_long_pause;
    logic [IVL_W-1:0] next_interval_ms;
    logic             periodic_off;
    logic [1:0]       pairs_judged;
    logic [1:0]       pairs_bad;
    logic [2:0]       entries_ignored;
  } tpa_out_t;

  // Control tag that travels with a record through the judge pipeline
  typedef struct packed {
    logic vld;     // stage holds a record
    logic store;   // periodic trimming on: record enters the history
    logic rec_ok;  // record is valid (measured, both sizes nonzero)
  } tpa_tag_t;

  // Contents of one history cell
  typedef struct packed {
    logic valid;   // entry valid
    logic bad;     // pair formed with the next older entry was bad
  } tpa_hist_t;

endpackage

>>> sv/tpa_cell.sv
// Trim pause advisor: one history cell of the shift chain.
// Depends on tpa_pkg for the cell contents type.

module tpa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  tpa_pkg::tpa_hist_t hist_i,
  output tpa_pkg::tpa_hist_t hist_o,
  output tpa_pkg::tpa_hist_t hist_next_o
);

  tpa_pkg::tpa_hist_t hist_q, hist_d;

  // Take the younger neighbor's contents on a shift
  always_comb begin
    hist_d = shift_i ? hist_i : hist_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  assign hist_o      = hist_q;
  assign hist_next_o = hist_d;

endmodule

>>> sv/tpa_judge.sv
// Trim pause advisor: four-stage pair judge.
// Holds the last stored record and judges it against each new one.
// Depends on tpa_pkg for widths and the control tag.

module tpa_judge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  tpa_pkg::tpa_tag_t              tag_i,
  input  logic [tpa_pkg::STAMP_W-1:0]    stamp_i,
  input  logic [tpa_pkg::DUR_W-1:0]      dur_i,
  input  logic [tpa_pkg::SIZE_W-1:0]     before_i,
  output tpa_pkg::tpa_tag_t              tag_o,
  output logic                           bad_o
);

  // Last stored record (earlier side of the pair)
  logic [tpa_pkg::STAMP_W-1:0] prev_stamp_q;
  logic [tpa_pkg::DUR_W-1:0]   prev_dur_q;
  logic [tpa_pkg::SIZE_W-1:0]  prev_before_q;

  // Stage 1: gap and size difference
  tpa_pkg::tpa_tag_t           s1_tag_q;
  logic [tpa_pkg::STAMP_W-1:0] s1_gap_q;
  logic                        s1_gap_pos_q;
  logic                        s1_grew_q;
  logic [tpa_pkg::SIZE_W-1:0]  s1_diff_q;
  logic [tpa_pkg::DUR_W-1:0]   s1_dur_q;
  logic [tpa_pkg::SIZE_W-1:0]  s1_b1_q;

  // Stage 2: partial products
  tpa_pkg::tpa_tag_t            s2_tag_q;
  logic [tpa_pkg::STAMP_W-1:0]  s2_gap_q;
  logic                         s2_gap_pos_q;
  logic                         s2_grew_q;
  logic [tpa_pkg::DUR100_W-1:0] s2_dur100_q;
  logic [63:0]                  s2_pa0_q;
  logic [47:0]                  s2_pa1_q;
  logic [63:0]                  s2_pb0_q;
  logic [47:0]                  s2_pb1_q;
  logic [47:0]                  s2_pb2_q;
  logic [31:0]                  s2_pb3_q;

  // Stage 3: assembled products and cost test
  tpa_pkg::tpa_tag_t         s3_tag_q;
  logic                      s3_gap_pos_q;
  logic                      s3_grew_q;
  logic                      s3_cost_ok_q;
  logic [tpa_pkg::LHS_W-1:0] s3_lhs_q;
  logic [tpa_pkg::RHS_W-1:0] s3_rhs_q;

  // Stage 4: verdict
  tpa_pkg::tpa_tag_t s4_tag_q;
  logic              s4_bad_q;

  // Control tags move with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
      s4_tag_q <= '0;
    end else if (adv_i) begin
      s1_tag_q <= tag_i;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      s4_tag_q <= s3_tag_q;
    end
  end

  // Earlier record is replaced only by a record that is stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_stamp_q  <= '0;
      prev_dur_q    <= '0;
      prev_before_q <= '0;
    end else if (adv_i && tag_i.vld && tag_i.store) begin
      prev_stamp_q  <= stamp_i;
      prev_dur_q    <= dur_i;
      prev_before_q <= before_i;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // stage 1
      s1_gap_q     <= stamp_i - prev_stamp_q;
      s1_gap_pos_q <= stamp_i > prev_stamp_q;
      s1_grew_q    <= before_i >= prev_before_q;
      s1_diff_q    <= prev_before_q - before_i;
      s1_dur_q     <= prev_dur_q;
      s1_b1_q      <= prev_before_q;
      // stage 2: operands split into 32-bit and 16-bit halves
      s2_gap_q     <= s1_gap_q;
      s2_gap_pos_q <= s1_gap_pos_q;
      s2_grew_q    <= s1_grew_q;
      s2_dur100_q  <= tpa_pkg::DUR100_W'(s1_dur_q) * tpa_pkg::COST_FACTOR;
      s2_pa0_q     <= 64'(s1_dur_q) * 64'(s1_b1_q[31:0]);
      s2_pa1_q     <= 48'(s1_dur_q) * 48'(s1_b1_q[47:32]);
      s2_pb0_q     <= 64'(s1_diff_q[31:0]) * 64'(s1_gap_q[31:0]);
      s2_pb1_q     <= 48'(s1_diff_q[31:0]) * 48'(s1_gap_q[47:32]);
      s2_pb2_q     <= 48'(s1_diff_q[47:32]) * 48'(s1_gap_q[31:0]);
      s2_pb3_q     <= 32'(s1_diff_q[47:32]) * 32'(s1_gap_q[47:32]);
      // stage 3
      s3_gap_pos_q <= s2_gap_pos_q;
      s3_grew_q    <= s2_grew_q;
      s3_cost_ok_q <= tpa_pkg::STAMP_W'(s2_dur100_q) >= s2_gap_q;
      s3_lhs_q     <= tpa_pkg::LHS_W'(s2_pa0_q) + {s2_pa1_q, 32'b0};
      s3_rhs_q     <= tpa_pkg::RHS_W'(s2_pb0_q) + tpa_pkg::RHS_W'({s2_pb1_q, 32'b0})
                    + tpa_pkg::RHS_W'({s2_pb2_q, 32'b0}) + {s2_pb3_q, 64'b0};
      // stage 4: bad when costly and the lasting gain does not cover the cost
      s4_bad_q     <= s3_gap_pos_q && s3_cost_ok_q &&
                      (s3_grew_q || (tpa_pkg::RHS_W'(s3_lhs_q) > s3_rhs_q));
    end
  end

  assign tag_o = s4_tag_q;
  assign bad_o = s4_bad_q;

endmodule

>>> sv/trim_pause_advisor.sv
// Trim pause advisor top level: one record per cycle; a record passes the four
// judge stages, then the output register. Throughput is set by the pair judge
// pipeline, whose wide products are split over two stages; a stalled output
// holds the whole pipeline and input ready follows it. Reset clears the history
// valid bits, the last stored record and both interval registers to zero.
// Depends on tpa_pkg, tpa_judge and tpa_cell.

module trim_pause_advisor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // record input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tpa_pkg::tpa_in_t                in_data_i,
  // advice output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tpa_pkg::tpa_out_t               out_data_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpa_pkg::IVL_W-1:0]       cfg_data_i
);

  localparam int D = tpa_pkg::HISTORY_DEPTH;

  logic [tpa_pkg::IVL_W-1:0] base_ivl_q, long_ivl_q;
  logic                      adv;
  tpa_pkg::tpa_tag_t         in_tag;
  tpa_pkg::tpa_tag_t         jd_tag;
  logic                      jd_bad;
  logic                      shift;
  tpa_pkg::tpa_hist_t        new_entry;
  tpa_pkg::tpa_hist_t        hist_q [D];
  tpa_pkg::tpa_hist_t        hist_d [D];
  logic [tpa_pkg::CNT_W-1:0] judged, bad, ignored;
  logic                      advise;
  logic                      out_valid_q;
  tpa_pkg::tpa_out_t         out_data_q, out_data_d;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_ivl_q <= '0;
      long_ivl_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tpa_pkg::REG_BASE_INTERVAL: base_ivl_q <= cfg_data_i;
        tpa_pkg::REG_LONG_INTERVAL: long_ivl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the output register is free or drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    in_tag.vld    = in_valid_i;
    in_tag.store  = base_ivl_q != '0;
    in_tag.rec_ok = in_data_i.measured && (in_data_i.size_before != '0) &&
                    (in_data_i.size_after != '0);
  end

  tpa_judge u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .tag_i    (in_tag),
    .stamp_i  (in_data_i.trim_stamp_ms),
    .dur_i    (in_data_i.trim_duration_ms),
    .before_i (in_data_i.size_before),
    .tag_o    (jd_tag),
    .bad_o    (jd_bad)
  );

  // History chain: cell 0 oldest, the youngest at the far end
  assign shift           = adv && jd_tag.vld && jd_tag.store;
  assign new_entry.valid = jd_tag.rec_ok;
  assign new_entry.bad   = jd_bad;

  for (genvar k = 0; k < D; k++) begin : g_cell
    if (k == D - 1) begin : g_tail
      tpa_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .shift_i     (shift),
        .hist_i      (new_entry),
        .hist_o      (hist_q[k]),
        .hist_next_o (hist_d[k])
      );
    end else begin : g_body
      tpa_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .shift_i     (shift),
        .hist_i      (hist_q[k+1]),
        .hist_o      (hist_q[k]),
        .hist_next_o (hist_d[k])
      );
    end
  end

  // Pair counts over the updated history; the oldest entry is always skipped
  always_comb begin
    judged  = '0;
    bad     = '0;
    ignored = tpa_pkg::CNT_W'(1);
    for (int k = 1; k < D; k++) begin
      if (hist_d[k].valid && hist_d[k-1].valid) begin
        judged = judged + tpa_pkg::CNT_W'(1);
        if (hist_d[k].bad) begin
          bad = bad + tpa_pkg::CNT_W'(1);
        end
      end else begin
        ignored = ignored + tpa_pkg::CNT_W'(1);
      end
    end
    advise = (ignored <= tpa_pkg::CNT_W'(1)) && (bad == judged);
  end

  // Result assembly
  always_comb begin
    if (jd_tag.store) begin
      out_data_d.advise_long_pause = advise;
      out_data_d.next_interval_ms  = advise ? long_ivl_q : base_ivl_q;
      out_data_d.periodic_off      = 1'b0;
      out_data_d.pairs_judged      = judged[1:0];
      out_data_d.pairs_bad         = bad[1:0];
      out_data_d.entries_ignored   = ignored[2:0];
    end else begin
      out_data_d                   = '0;
      out_data_d.periodic_off      = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= jd_tag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && jd_tag.vld) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/tpa_checker.sv
// Trim pause advisor: port-level checker and its bind to the top level.
// Depends on tpa_pkg and trim_pause_advisor.

module tpa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input tpa_pkg::tpa_out_t               out_data_o
);

  // A result waiting for transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Periodic trimming off gives an empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.periodic_off |->
      !out_data_o.advise_long_pause && out_data_o.next_interval_ms == '0 &&
      out_data_o.pairs_judged == '0 && out_data_o.pairs_bad == '0 &&
      out_data_o.entries_ignored == '0)
    else $error("periodic-off result not empty");

  // Advice only with a full valid history of bad pairs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.advise_long_pause |->
      !out_data_o.periodic_off && out_data_o.pairs_bad == out_data_o.pairs_judged &&
      out_data_o.entries_ignored == 3'd1)
    else $error("pause advised without full bad history");

  // Bad pairs never outnumber judged ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pairs_bad <= out_data_o.pairs_judged)
    else $error("more bad pairs than judged pairs");

endmodule

bind trim_pause_advisor tpa_checker u_tpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> verif/trim_pause_advisor_test.sv
// Testbench for trim_pause_advisor: drives trim records and interval writes,
// predicts each advice from its own copy of the history ring, and checks results.
// Depends on tpa_pkg and the trim_pause_advisor RTL.
`timescale 1ns / 1ps

module trim_pause_advisor_test;
  import tpa_pkg::*;

  typedef enum int unsigned {REC_CLEAN, REC_BROKEN, REC_NOISE} rec_kind_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tpa_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  tpa_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IVL_W-1:0]     cfg_data = '0;

  // predictor copy of the block state
  logic [STAMP_W-1:0] ring_stamp  [HISTORY_DEPTH];
  logic [DUR_W-1:0]   ring_dur    [HISTORY_DEPTH];
  logic [SIZE_W-1:0]  ring_before [HISTORY_DEPTH];
  logic               ring_valid  [HISTORY_DEPTH];
  int unsigned        ring_head = 0;
  logic [IVL_W-1:0]   base_ivl = '0;
  logic [IVL_W-1:0]   long_ivl = '0;

  tpa_out_t    pending_advice[$];
  int unsigned fail_count = 0;

  // idling controls
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned hold_cycles = 0;

  // record generator chain state
  logic [STAMP_W-1:0] chain_stamp;
  logic [SIZE_W-1:0]  chain_before;
  logic [STAMP_W-1:0] next_gap;

  trim_pause_advisor u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      ring_stamp[k]  = '0;
      ring_dur[k]    = '0;
      ring_before[k] = '0;
      ring_valid[k]  = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A pair is bad when the trim cost >= 1% of the gap and the lasting gain
  // does not pay for it; exact wide products, non-positive gap never bad.
  function automatic bit trim_not_worth(logic [STAMP_W-1:0] s1, logic [STAMP_W-1:0] s2,
                                        logic [DUR_W-1:0] dur, logic [SIZE_W-1:0] b1,
                                        logic [SIZE_W-1:0] b2);
    logic [127:0] gap;
    logic [127:0] lhs;
    logic [127:0] rhs;
    if (s2 <= s1) return 1'b0;
    gap = 128'(s2 - s1);
    if (128'(dur) * 128'd100 < gap) return 1'b0;
    if (b2 >= b1) return 1'b1;
    lhs = 128'(dur) * 128'(b1);
    rhs = 128'(b1 - b2) * gap;
    return lhs > rhs;
  endfunction

  // Store the record, walk the ring oldest to youngest and form the advice
  function automatic tpa_out_t predict_advice(tpa_in_t rec);
    tpa_out_t    res;
    int unsigned judged;
    int unsigned bad;
    int unsigned ignored;
    int unsigned slot;
    int unsigned prev;
    int unsigned i;
    bit          have_prev;
    bit          advise;
    res = '0;
    if (base_ivl == '0) begin
      res.periodic_off = 1'b1;
      return res;
    end
    ring_stamp[ring_head]  = rec.trim_stamp_ms;
    ring_dur[ring_head]    = rec.trim_duration_ms;
    ring_before[ring_head] = rec.size_before;
    ring_valid[ring_head]  = rec.measured && rec.size_before != '0 && rec.size_after != '0;
    ring_head = (ring_head + 1) % HISTORY_DEPTH;

    judged = 0;
    bad = 0;
    ignored = 0;
    have_prev = 1'b0;
    prev = 0;
    slot = ring_head;
    for (i = 0; i < HISTORY_DEPTH; i++) begin
      if (!ring_valid[slot] || !have_prev || !ring_valid[prev]) begin
        ignored++;
      end else begin
        judged++;
        if (trim_not_worth(ring_stamp[prev], ring_stamp[slot], ring_dur[prev],
                           ring_before[prev], ring_before[slot])) bad++;
      end
      prev = slot;
      have_prev = 1'b1;
      slot = (slot + 1) % HISTORY_DEPTH;
    end

    advise = (ignored <= 1) && (bad == judged);
    res.advise_long_pause = advise;
    res.next_interval_ms  = advise ? long_ivl : base_ivl;
    res.pairs_judged      = 2'(judged);
    res.pairs_bad         = 2'(bad);
    res.entries_ignored   = 3'(ignored);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    tpa_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_advice.size() == 0) begin
          $error("advice transfer with no record outstanding");
          fail_count++;
        end else begin
          want = pending_advice.pop_front();
          check_field("advise_long_pause", 32'(want.advise_long_pause),
                      32'(out_data.advise_long_pause));
          check_field("next_interval_ms", want.next_interval_ms, out_data.next_interval_ms);
          check_field("periodic_off", 32'(want.periodic_off), 32'(out_data.periodic_off));
          check_field("pairs_judged", 32'(want.pairs_judged), 32'(out_data.pairs_judged));
          check_field("pairs_bad", 32'(want.pairs_bad), 32'(out_data.pairs_bad));
          check_field("entries_ignored", 32'(want.entries_ignored),
                      32'(out_data.entries_ignored));
        end
      end
    end
  end

  // Receiver: long hold-off on request, random stall bursts when enabled
  initial begin
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One record transfer; valid is left high so the next record can follow
  task automatic send_record(tpa_in_t rec);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rec;
    do @(posedge clk); while (!in_ready);
    pending_advice.push_back(predict_advice(rec));
  endtask

  // Stop sending and wait for every outstanding advice
  task automatic drain_advice();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_advice.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [IVL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_BASE_INTERVAL) base_ivl = value;
    else if (index == REG_LONG_INTERVAL) long_ivl = value;
  endtask

  // Both intervals, sometimes preceded by a write to an unmapped index
  task automatic set_intervals(logic [IVL_W-1:0] base_v, logic [IVL_W-1:0] long_v);
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
    write_reg(REG_BASE_INTERVAL, base_v);
    write_reg(REG_LONG_INTERVAL, long_v);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Record generation
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic tpa_in_t mk_rec(logic [STAMP_W-1:0] stamp, logic [DUR_W-1:0] dur,
                                     logic [SIZE_W-1:0] before_v, logic [SIZE_W-1:0] after,
                                     logic meas);
    tpa_in_t r;
    r.trim_stamp_ms    = stamp;
    r.trim_duration_ms = dur;
    r.size_before      = before_v;
    r.size_after       = after;
    r.measured         = meas;
    return r;
  endfunction

  function automatic void restart_chain();
    chain_stamp  = 48'($urandom);
    chain_before = rand48() | 48'h1;
    next_gap     = 48'($urandom_range(1, 5000));
  endfunction

  // Clean records form a rising-stamp chain whose duration is sized against
  // the gap to the following record, so most pairs sit near the cost limit.
  function automatic tpa_in_t make_record(rec_kind_e kind);
    tpa_in_t     r;
    int unsigned pick;
    r.trim_stamp_ms = chain_stamp + next_gap;
    chain_stamp = r.trim_stamp_ms;

    pick = $urandom_range(0, 9);
    if (pick == 0) next_gap = rand48();
    else if (pick < 3) next_gap = 48'($urandom);
    else next_gap = 48'($urandom_range(1, 5000));

    pick = $urandom_range(0, 9);
    if (pick < 6) r.trim_duration_ms = 32'(next_gap / 100) + 32'($urandom_range(0, 40));
    else if (pick < 8) r.trim_duration_ms = 32'(next_gap / 100);
    else r.trim_duration_ms = $urandom;

    // footprint drift: small drops keep pairs bad, large drops make them pay off
    case ($urandom_range(0, 3))
      0: begin
        chain_before = chain_before + 48'($urandom_range(0, 1 << 20));
      end
      1: begin
        chain_before = chain_before - (chain_before >> $urandom_range(5, 12));
      end
      2: begin
        chain_before = chain_before - (chain_before >> $urandom_range(1, 4));
      end
      default: begin
        chain_before = chain_before - 48'($urandom_range(0, 1000));
      end
    endcase
    if (chain_before == '0) chain_before = rand48() | 48'h1;
    r.size_before = chain_before;
    r.size_after  = (chain_before >> $urandom_range(0, 8)) | 48'h1;
    r.measured    = 1'b1;

    if (kind == REC_BROKEN) begin
      case ($urandom_range(0, 3))
        0: begin
          r.measured = 1'b0;
        end
        1: begin
          r.size_before = '0;
        end
        2: begin
          r.size_after = '0;
        end
        default: begin
          r.trim_stamp_ms = r.trim_stamp_ms - 48'($urandom_range(0, 3000));
        end
      endcase
    end else if (kind == REC_NOISE) begin
      r.trim_stamp_ms    = rand48();
      r.trim_duration_ms = $urandom;
      r.size_before      = ($urandom_range(0, 3) == 0) ? '0 : rand48();
      r.size_after       = ($urandom_range(0, 3) == 0) ? '0 : rand48();
      r.measured         = 1'($urandom);
    end
    return r;
  endfunction

  task automatic send_mixed(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_record(make_record(REC_CLEAN));
      else if (pick < 85) send_record(make_record(REC_BROKEN));
      else send_record(make_record(REC_NOISE));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Base interval still zero from reset: nothing stored, periodic_off set
  task automatic test_periodic_off();
    send_record(mk_rec(48'd1000, 32'd20, 48'd1_000_000, 48'd500_000, 1'b1));
    send_record(mk_rec(48'd2000, 32'd20, 48'd999_999, 48'd500_000, 1'b1));
    send_record(mk_rec('1, '1, '1, '1, 1'b1));
    send_record(mk_rec('0, '0, '0, '0, 1'b0));
    drain_advice();
  endtask

  // Hand-built pairs around each decision boundary
  task automatic test_pair_judgment();
    set_intervals(32'd1000, 32'd60000);
    // four costly trims with a shrinking footprint: every pair bad
    send_record(mk_rec(48'd1000, 32'd20, 48'd1_000_000, 48'd500_000, 1'b1));
    send_record(mk_rec(48'd2000, 32'd20, 48'd999_999, 48'd500_000, 1'b1));
    send_record(mk_rec(48'd3000, 32'd20, 48'd999_998, 48'd500_000, 1'b1));
    send_record(mk_rec(48'd4000, 32'd20, 48'd999_997, 48'd500_000, 1'b1));
    // footprint grew: bad
    send_record(mk_rec(48'd5000, 32'd10, 48'd2_000_000, 48'd1_000_000, 1'b1));
    // cost exactly 1% of the gap, equal footprint: bad
    send_record(mk_rec(48'd6000, 32'd10, 48'd2_000_000, 48'd1_000_000, 1'b1));
    // products tie: not bad
    send_record(mk_rec(48'd7000, 32'd9, 48'd1_980_000, 48'd1_000_000, 1'b1));
    // cost just under 1%: not bad
    send_record(mk_rec(48'd8000, 32'd500, 48'd1_970_000, 48'd1_000_000, 1'b1));
    // equal stamps, then a stamp going backwards: judged, never bad
    send_record(mk_rec(48'd8000, 32'd500, 48'd1_960_000, 48'd1_000_000, 1'b1));
    send_record(mk_rec(48'd7500, 32'd500, 48'd1_950_000, 48'd1_000_000, 1'b1));
    // invalid records: unmeasured, zero size before, zero size after
    send_record(mk_rec(48'd9000, 32'd50, 48'd1_000_000, 48'd1, 1'b0));
    send_record(mk_rec(48'd10000, 32'd50, 48'd0, 48'd5, 1'b1));
    send_record(mk_rec(48'd11000, 32'd50, 48'd5, 48'd0, 1'b1));
    // field extremes and stamp wrap
    send_record(mk_rec(48'd12000, '1, '1, '1, 1'b1));
    send_record(mk_rec('1, '1, '1, '1, 1'b1));
    send_record(mk_rec('0, '1, '1, '1, 1'b1));
    send_record(mk_rec(48'd1, '0, 48'd1, 48'd1, 1'b1));
    // widest products
    send_record(mk_rec(48'd100, '1, '1, 48'd1, 1'b1));
    send_record(mk_rec(48'h0000_FFFF_FFFF, '1, 48'd1, 48'd1, 1'b1));
    send_record(mk_rec(48'h0001_0000_0030, 32'd1, 48'h8000_0000_0000, 48'd1, 1'b1));
    send_record(mk_rec(48'h0001_0000_0031, 32'd1, 48'h7FFF_FFFF_FFFF, 48'd1, 1'b1));
    drain_advice();
  endtask

  // Interval registers at their extremes, plus a write to an unmapped index
  task automatic test_interval_extremes();
    restart_chain();
    set_intervals('1, '0);
    send_mixed(12);
    drain_advice();
    write_reg(8'hFF, '1);
    set_intervals(32'd1, '1);
    send_mixed(12);
    drain_advice();
  endtask

  // Receiver holds off while records keep coming, so the pipe fills and input
  // ready drops; then the sender waits for the backlog before going on.
  task automatic test_backpressure();
    set_intervals(32'($urandom_range(1, 100000)), $urandom);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_cycles = 150;
    send_mixed(30);
    drain_advice();
    send_mixed(10);
    drain_advice();
  endtask

  // Random phases across several settings, idling on both sides
  task automatic test_random_traffic();
    int unsigned phase;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      restart_chain();
      case (phase)
        0: set_intervals($urandom, $urandom);
        1: set_intervals(32'd1, '1);
        2: set_intervals('1, '0);
        default: set_intervals(32'($urandom_range(1, 600000)), $urandom);
      endcase
      send_mixed(50);
      drain_advice();
    end
    // periodic trimming switched off mid-run, then back on
    set_intervals('0, $urandom);
    send_mixed(15);
    drain_advice();
    set_intervals($urandom | 32'h1, $urandom);
    send_mixed(10);
    drain_advice();
  endtask

  // Final stretch with no idling on either side
  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    restart_chain();
    set_intervals(32'($urandom_range(1, 100000)), $urandom);
    send_mixed(60);
    drain_advice();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_periodic_off();
    test_pair_judgment();
    test_interval_extremes();
    test_backpressure();
    test_random_traffic();
    test_full_rate();

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
